// File: rtl/sas_pkg.sv
// Package: shared constants, types and helpers for the alignment score block.
package sas_pkg;

  localparam int unsigned QueryMaxDef   = 64;
  localparam int unsigned SubjectMaxDef = 65535;
  localparam int unsigned ScoreW        = 25;
  localparam int unsigned CfgW          = 8;
  localparam int unsigned RowW          = 7;
  localparam int unsigned ColW          = 16;
  localparam int unsigned CodeW         = 3;
  localparam int unsigned QidxW         = 6;
  localparam int unsigned CfgIdxW       = 3;

  typedef logic signed [ScoreW-1:0] score_t;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMatch    = 3'd0,
    CfgMismatch = 3'd1,
    CfgGap      = 3'd2,
    CfgLocal    = 3'd3,
    CfgQlen     = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    ReqQuery   = 1'b0,
    ReqSubject = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    StIdle,
    StRun,
    StDrain,
    StOut
  } state_e;

  // Shared settings handed from the top level to every cell.
  typedef struct packed {
    logic signed [CfgW-1:0] match_score;
    logic signed [CfgW-1:0] mismatch_score;
    logic signed [CfgW-1:0] gap_penalty;
    logic                   local_mode;
  } cell_cfg_t;

  localparam logic signed [ScoreW+1:0] SatMin = -(27'sd16777216);
  localparam logic signed [ScoreW+1:0] SatMax = 27'sd16777215;

  // Clamp a 27-bit sum to the score range.
  function automatic score_t sat27(input logic signed [ScoreW+1:0] v);
    score_t r;
    if (v < SatMin) begin
      r = SatMin[ScoreW-1:0];
    end else if (v > SatMax) begin
      r = SatMax[ScoreW-1:0];
    end else begin
      r = v[ScoreW-1:0];
    end
    return r;
  endfunction

  function automatic score_t add_sat(input score_t a, input logic signed [CfgW-1:0] b);
    logic signed [ScoreW+1:0] s;
    s = (ScoreW+2)'(a) + (ScoreW+2)'(b);
    return sat27(s);
  endfunction

endpackage

// File: rtl/sas_cell.sv
// Cell: one query row of the score matrix, one subject column per step.
module sas_cell #(
  parameter int unsigned RowIdxW = 7,
  parameter int unsigned ColIdxW = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  sas_pkg::cell_cfg_t           cfg_i,
  input  logic [RowIdxW-1:0]           row_i,
  input  logic [RowIdxW-1:0]           rows_i,
  input  logic                         q_we_i,
  input  logic [sas_pkg::CodeW-1:0]    q_code_i,
  input  logic                         clear_i,
  // wavefront from the row above
  input  logic                         step_i,
  input  logic [sas_pkg::CodeW-1:0]    base_i,
  input  logic [ColIdxW-1:0]           col_i,
  input  logic                         first_i,
  input  sas_pkg::score_t              north_i,
  input  sas_pkg::score_t              diag_i,
  input  sas_pkg::score_t              west_edge_i,
  // wavefront to the row below
  output logic                         step_o,
  output logic [sas_pkg::CodeW-1:0]    base_o,
  output logic [ColIdxW-1:0]           col_o,
  output logic                         first_o,
  output sas_pkg::score_t              north_o,
  output sas_pkg::score_t              diag_o,
  output sas_pkg::score_t              west_edge_o,
  output sas_pkg::score_t              cur_o,
  output sas_pkg::score_t              best_o,
  output logic [ColIdxW-1:0]           best_col_o
);
  import sas_pkg::*;

  logic [CodeW-1:0]  qcode_q;
  score_t            col_q, col_d;
  score_t            best_q, best_d;
  logic [ColIdxW-1:0] bcol_q, bcol_d;
  logic              step_q;
  logic [CodeW-1:0]  base_q;
  logic [ColIdxW-1:0] colr_q;
  logic              first_q;
  score_t            diag_q, wedge_q;
  logic              active;

  score_t west, v, w, d, vmax;
  logic signed [CfgW-1:0] pair;

  always_comb begin
    // Rows past the query length in use keep their scores.
    active = (row_i <= rows_i);
    // On the first column the west value is this row's edge.
    west = first_i ? west_edge_i : col_q;
    pair = (qcode_q == base_i) ? cfg_i.match_score : cfg_i.mismatch_score;
    v = add_sat(north_i, cfg_i.gap_penalty);
    w = add_sat(west, cfg_i.gap_penalty);
    d = add_sat(diag_i, pair);
    vmax = v;
    if (w > vmax) vmax = w;
    if (d > vmax) vmax = d;
    if (cfg_i.local_mode && vmax < 0) vmax = '0;
    col_d  = vmax;
    best_d = best_q;
    bcol_d = bcol_q;
    // Columns reach this row in order, so strictly larger keeps the earliest.
    if (cfg_i.local_mode && vmax > best_q) begin
      best_d = vmax;
      bcol_d = col_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_we_i) qcode_q <= q_code_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0;
      col_q  <= '0;
      best_q <= '0;
      bcol_q <= '0;
    end else if (clear_i) begin
      step_q <= 1'b0;
      col_q  <= '0;
      best_q <= '0;
      bcol_q <= '0;
    end else begin
      step_q <= step_i;
      if (step_i && active) begin
        col_q  <= col_d;
        best_q <= best_d;
        bcol_q <= bcol_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      base_q  <= base_i;
      colr_q  <= col_i;
      first_q <= first_i;
      diag_q  <= west;
      wedge_q <= west_edge_i;
    end
  end

  assign step_o      = step_q;
  assign base_o      = base_q;
  assign col_o       = colr_q;
  assign first_o     = first_q;
  assign north_o     = col_q;
  assign diag_o      = diag_q;
  assign cur_o       = col_q;
  assign best_o      = best_q;
  assign best_col_o  = bcol_q;
  // next row's edge: this row's edge plus one gap step, zero in local mode
  assign west_edge_o = (first_q && !cfg_i.local_mode) ? add_sat(wedge_q, cfg_i.gap_penalty)
                                                       : '0;
endmodule

// File: rtl/sequence_alignment_score.sv
// Top level: linear-gap alignment score over a systolic row of query cells.
//
//  channel | direction | payload
//  --------+-----------+---------------------------------------------
//  in      | input     | req_type, query_index, base_code, last_base
//  out     | output    | best_score, end_row, end_col
//  cfg     | input     | cfg_we_i, cfg_idx_i, cfg_data_i (no handshake)
//
// A subject base enters the cell row in the cycle it transfers and moves one
// row per cycle, so a new base is taken each cycle while no drain or result
// is pending. A query load holds while a column is still moving down the row.
// A last base starts a drain, during which the wavefront clears the last row
// and the local best is scanned one row a cycle; out_valid rises after the
// drain and the result holds until taken, with the input stalled.
// Reset clears all control, the cell scores and the best cell.
module sequence_alignment_score #(
  parameter int unsigned QueryMax   = sas_pkg::QueryMaxDef,
  parameter int unsigned SubjectMax = sas_pkg::SubjectMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [sas_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sas_pkg::CfgW-1:0]      cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          req_type_i,
  input  logic [sas_pkg::QidxW-1:0]     query_index_i,
  input  logic [sas_pkg::CodeW-1:0]     base_code_i,
  input  logic                          last_base_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [sas_pkg::ScoreW-1:0] best_score_o,
  output logic [sas_pkg::RowW-1:0]      end_row_o,
  output logic [sas_pkg::ColW-1:0]      end_col_o
);
  import sas_pkg::*;

  localparam int unsigned N    = QueryMax;
  localparam int unsigned RIW  = RowW;
  localparam int unsigned CIW  = ColW;
  localparam int unsigned CntW = $clog2(N + 2);
  localparam int unsigned SelW = $clog2(N);

  // configuration registers
  cell_cfg_t cfg_q;
  logic [RowW-1:0] qlen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_score    <= 8'sd1;
      cfg_q.mismatch_score <= -8'sd1;
      cfg_q.gap_penalty    <= -8'sd2;
      cfg_q.local_mode     <= 1'b0;
      qlen_q               <= RowW'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgMatch:    cfg_q.match_score    <= cfg_data_i;
        CfgMismatch: cfg_q.mismatch_score <= cfg_data_i;
        CfgGap:      cfg_q.gap_penalty    <= cfg_data_i;
        CfgLocal:    cfg_q.local_mode     <= cfg_data_i[0];
        CfgQlen:     qlen_q               <= cfg_data_i[RowW-1:0];
        default: ;
      endcase
    end
  end

  // rows in use: zero acts as one, clamp to the cell count
  logic [RowW-1:0] rows;
  always_comb begin
    if (qlen_q == '0) rows = RowW'(1);
    else if (32'(qlen_q) > N) rows = RowW'(N);
    else rows = qlen_q;
  end

  // control
  state_e state_q, state_d;
  logic [CIW-1:0]  count_q;
  logic [CntW-1:0] drain_q;
  logic in_fire, out_fire, subj, add_col;
  logic wave_busy;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;
  assign subj     = in_fire && (req_type_i == ReqSubject);
  assign add_col  = subj && (32'(count_q) < SubjectMax);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle, StRun: begin
        if (subj && last_base_i) state_d = StDrain;
        else if (subj) state_d = StRun;
      end
      StDrain: if (drain_q == '0) state_d = StOut;
      StOut:   if (out_fire) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Hold a query load until no column is left on its way down the row.
  always_comb begin
    in_ready_o  = ((state_q == StIdle) || (state_q == StRun)) &&
                  !(req_type_i == ReqQuery && wave_busy);
    out_valid_o = (state_q == StOut);
  end

  logic clear;
  assign clear = out_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      drain_q <= '0;
    end else begin
      state_q <= state_d;
      if (clear) count_q <= '0;
      else if (add_col) count_q <= count_q + 1'b1;
      if (subj && last_base_i) drain_q <= CntW'(rows);
      else if (state_q == StDrain && drain_q != '0) drain_q <= drain_q - 1'b1;
    end
  end

  // cell row
  logic               step_w  [N+1];
  logic [CodeW-1:0]   base_w  [N+1];
  logic [CIW-1:0]     col_w   [N+1];
  logic               first_w [N+1];
  score_t             north_w [N+1];
  score_t             diag_w  [N+1];
  score_t             wedge_w [N+1];
  score_t             cur_w   [N];
  score_t             best_w  [N];
  logic [CIW-1:0]     bcol_w  [N];

  always_comb begin
    wave_busy = 1'b0;
    for (int k = 1; k < N; k++) wave_busy = wave_busy | step_w[k];
  end

  assign step_w[0]  = add_col;
  assign base_w[0]  = base_code_i;
  assign col_w[0]   = count_q + 1'b1;
  assign first_w[0] = (count_q == '0);
  // top edge of column j is gap*j; row zero diagonal is the previous top edge
  logic signed [ScoreW+1:0] top_prod;
  assign top_prod = (ScoreW+2)'(cfg_q.gap_penalty) * $signed({1'b0, col_w[0]});
  score_t top_q;
  assign north_w[0] = cfg_q.local_mode ? '0 : sat27(top_prod);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) top_q <= '0;
    else if (clear) top_q <= '0;
    else if (add_col) top_q <= north_w[0];
  end
  assign diag_w[0]  = top_q;
  // row one edge on the first column is gap*1
  assign wedge_w[0] = north_w[0];

  for (genvar g = 0; g < N; g++) begin : g_cell
    sas_cell #(.RowIdxW(RIW), .ColIdxW(CIW)) u_cell (
      .clk_i, .rst_ni,
      .cfg_i       (cfg_q),
      .row_i       (RIW'(g + 1)),
      .rows_i      (rows),
      .q_we_i      (in_fire && req_type_i == ReqQuery && 32'(query_index_i) == g),
      .q_code_i    (base_code_i),
      .clear_i     (clear),
      .step_i      (step_w[g]),
      .base_i      (base_w[g]),
      .col_i       (col_w[g]),
      .first_i     (first_w[g]),
      .north_i     (north_w[g]),
      .diag_i      (diag_w[g]),
      .west_edge_i (wedge_w[g]),
      .step_o      (step_w[g+1]),
      .base_o      (base_w[g+1]),
      .col_o       (col_w[g+1]),
      .first_o     (first_w[g+1]),
      .north_o     (north_w[g+1]),
      .diag_o      (diag_w[g+1]),
      .west_edge_o (wedge_w[g+1]),
      .cur_o       (cur_w[g]),
      .best_o      (best_w[g]),
      .best_col_o  (bcol_w[g])
    );
  end

  // Global edge for an empty subject: gap * rows, built one row a cycle.
  score_t edge_q;
  logic [RowW-1:0] ecnt_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_q <= '0;
      ecnt_q <= '0;
    end else if (subj && last_base_i) begin
      edge_q <= '0;
      ecnt_q <= '0;
    end else if (state_q == StDrain && ecnt_q < rows) begin
      edge_q <= add_sat(edge_q, cfg_q.gap_penalty);
      ecnt_q <= ecnt_q + 1'b1;
    end
  end

  // Local best: walk rows during drain, ties keep the smallest row.
  score_t lbest_q;
  logic [RowW-1:0] lrow_q;
  logic [CIW-1:0]  lcol_q;
  logic [RowW-1:0] scan_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lbest_q <= '0; lrow_q <= '0; lcol_q <= '0; scan_q <= '0;
    end else if (subj && last_base_i) begin
      lbest_q <= '0; lrow_q <= '0; lcol_q <= '0; scan_q <= '0;
    end else if (state_q == StDrain && scan_q < rows) begin
      scan_q <= scan_q + 1'b1;
      if (best_w[scan_q[SelW-1:0]] > lbest_q) begin
        lbest_q <= best_w[scan_q[SelW-1:0]];
        lrow_q  <= scan_q + 1'b1;
        lcol_q  <= bcol_w[scan_q[SelW-1:0]];
      end
    end
  end

  logic [RowW-1:0] last_row;
  assign last_row = rows - 1'b1;

  // The drain covers both the wavefront and the scan.
  always_comb begin
    if (cfg_q.local_mode) begin
      best_score_o = lbest_q;
      end_row_o    = lrow_q;
      end_col_o    = lcol_q;
    end else begin
      best_score_o = (count_q == '0) ? edge_q : cur_w[last_row[SelW-1:0]];
      end_row_o    = rows;
      end_col_o    = count_q;
    end
  end
endmodule

// File: rtl/sas_checker.sv
// Checker: port-level properties of the alignment score block.
module sas_props (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic [sas_pkg::RowW-1:0] end_row_o
);
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("input taken during result");
  a_row_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(end_row_o)) else $error("row moved");
  a_out_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i |=> !out_valid_o) else $error("result repeated");
endmodule

bind sequence_alignment_score sas_props u_sas_props (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i, .end_row_o
);

// File: verif/sas_checker.sv
// Checker: predicts alignment scores from observed transfers and compares results.
module sas_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sas_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sas_pkg::CfgW-1:0]          cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic                              req_type_i,
  input  logic [sas_pkg::QidxW-1:0]         query_index_i,
  input  logic [sas_pkg::CodeW-1:0]         base_code_i,
  input  logic                              last_base_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [sas_pkg::ScoreW-1:0] best_score_i,
  input  logic [sas_pkg::RowW-1:0]          end_row_i,
  input  logic [sas_pkg::ColW-1:0]          end_col_i,
  output int unsigned                       errors_o,
  output int unsigned                       pending_o
);
  import sas_pkg::*;

  localparam int unsigned NumRows = QueryMaxDef;
  localparam int unsigned MaxCols = SubjectMaxDef;
  localparam longint ScoreLo = -16777216;
  localparam longint ScoreHi = 16777215;

  typedef struct {
    logic signed [ScoreW-1:0] score;
    logic [RowW-1:0]          row;
    logic [ColW-1:0]          col;
  } align_result_t;

  align_result_t expected_scores[$];

  logic [CodeW-1:0] query_bases[NumRows];
  longint           prev_column[NumRows+1];
  int unsigned      columns_seen;
  longint           peak_score;
  int unsigned      peak_row;
  int unsigned      peak_col;

  longint      match_val, mismatch_val, gap_val;
  logic        local_on;
  logic [6:0]  qlen_reg;

  function automatic longint clamp_score(longint v);
    if (v < ScoreLo) return ScoreLo;
    if (v > ScoreHi) return ScoreHi;
    return v;
  endfunction

  function automatic longint border_score(int unsigned k);
    if (local_on) return 0;
    return clamp_score(gap_val * longint'(k));
  endfunction

  function automatic int unsigned active_rows();
    if (qlen_reg == 0) return 1;
    if (qlen_reg > NumRows) return NumRows;
    return qlen_reg;
  endfunction

  // Advance one subject column and queue a result on the last base.
  task automatic score_subject_base(logic [CodeW-1:0] code, logic last);
    longint        fresh[NumRows+1];
    longint        diag, left, pair, v, w, d;
    int unsigned   rows, col;
    align_result_t res;
    rows = active_rows();
    if (columns_seen < MaxCols) begin
      col = columns_seen + 1;
      fresh[0] = border_score(col);
      for (int unsigned i = 1; i <= rows; i++) begin
        diag = columns_seen ? prev_column[i-1] : border_score(i - 1);
        left = columns_seen ? prev_column[i] : border_score(i);
        pair = (query_bases[i-1] == code) ? match_val : mismatch_val;
        v = clamp_score(fresh[i-1] + gap_val);
        w = clamp_score(left + gap_val);
        d = clamp_score(diag + pair);
        if (w > v) v = w;
        if (d > v) v = d;
        if (local_on) begin
          if (v < 0) v = 0;
          if (v > peak_score || (v == peak_score && i < peak_row)) begin
            peak_score = v;
            peak_row   = i;
            peak_col   = col;
          end
        end
        fresh[i] = v;
      end
      for (int unsigned i = 0; i <= rows; i++) prev_column[i] = fresh[i];
      columns_seen = col;
    end
    if (last) begin
      if (local_on) begin
        res.score = peak_score[ScoreW-1:0];
        res.row   = peak_row[RowW-1:0];
        res.col   = peak_col[ColW-1:0];
      end else begin
        v = columns_seen ? prev_column[rows] : border_score(rows);
        res.score = v[ScoreW-1:0];
        res.row   = rows[RowW-1:0];
        res.col   = columns_seen[ColW-1:0];
      end
      expected_scores.push_back(res);
      columns_seen = 0;
      peak_score   = 0;
      peak_row     = 0;
      peak_col     = 0;
      for (int unsigned i = 0; i <= NumRows; i++) prev_column[i] = 0;
    end
  endtask

  assign pending_o = expected_scores.size();

  always @(posedge clk_i or negedge rst_ni) begin
    align_result_t exp_res;
    if (!rst_ni) begin
      match_val    = 1;
      mismatch_val = -1;
      gap_val      = -2;
      local_on     = 1'b0;
      qlen_reg     = 7'd64;
      columns_seen = 0;
      peak_score   = 0;
      peak_row     = 0;
      peak_col     = 0;
      errors_o     = 0;
      for (int unsigned i = 0; i < NumRows; i++) query_bases[i] = '0;
      for (int unsigned i = 0; i <= NumRows; i++) prev_column[i] = 0;
      expected_scores.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_scores.size() == 0) begin
          $display("%0t: unexpected result score=%0d row=%0d col=%0d", $time,
                   best_score_i, end_row_i, end_col_i);
          errors_o++;
        end else begin
          exp_res = expected_scores.pop_front();
          if (best_score_i !== exp_res.score) begin
            $display("%0t: best_score expected %0d got %0d", $time,
                     exp_res.score, best_score_i);
            errors_o++;
          end
          if (end_row_i !== exp_res.row) begin
            $display("%0t: end_row expected %0d got %0d", $time, exp_res.row, end_row_i);
            errors_o++;
          end
          if (end_col_i !== exp_res.col) begin
            $display("%0t: end_col expected %0d got %0d", $time, exp_res.col, end_col_i);
            errors_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (req_type_i == ReqQuery) begin
          query_bases[query_index_i] = base_code_i;
        end else begin
          score_subject_base(base_code_i, last_base_i);
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgMatch:    match_val    = longint'($signed(cfg_data_i));
          CfgMismatch: mismatch_val = longint'($signed(cfg_data_i));
          CfgGap:      gap_val      = longint'($signed(cfg_data_i));
          CfgLocal:    local_on     = cfg_data_i[0];
          CfgQlen:     qlen_reg     = cfg_data_i[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// File: verif/testbench.sv
// Testbench top: drives stimulus into the alignment score block and gives the verdict.
module testbench;
  import sas_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam int unsigned DrainCycles = 100;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     cfg_we_i;
  logic [CfgIdxW-1:0]       cfg_idx_i;
  logic [CfgW-1:0]          cfg_data_i;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic                     req_type_i;
  logic [QidxW-1:0]         query_index_i;
  logic [CodeW-1:0]         base_code_i;
  logic                     last_base_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic signed [ScoreW-1:0] best_score_o;
  logic [RowW-1:0]          end_row_o;
  logic [ColW-1:0]          end_col_o;

  int unsigned errors;
  int unsigned pending;
  int unsigned quiet_cycles;
  bit          send_busy;   // sender idles at random
  bit          recv_busy;   // receiver stalls at random

  sequence_alignment_score u_dut (.*);

  sas_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .req_type_i, .query_index_i,
    .base_code_i, .last_base_i,
    .out_valid_i(out_valid_o), .out_ready_i, .best_score_i(best_score_o),
    .end_row_i(end_row_o), .end_col_i(end_col_o),
    .errors_o(errors), .pending_o(pending)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: toggle ready at the falling edge with random stall lengths.
  always @(negedge clk_i) begin
    int unsigned hold;
    if (!rst_ni || !recv_busy) begin
      out_ready_i <= 1'b1;
    end else begin
      hold = pick_gap();
      out_ready_i <= (hold == 0);
      repeat (hold) @(negedge clk_i);
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("[sequence_alignment_score] ERROR");
        $finish;
      end
    end
  end

  // Present one item and hold it until it transfers.
  task automatic send_item(logic req, logic [QidxW-1:0] idx, logic [CodeW-1:0] code,
                           logic last);
    int unsigned gap;
    gap = send_busy ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    = 1'b1;
    req_type_i    = req;
    query_index_i = idx;
    base_code_i   = code;
    last_base_i   = last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic go_idle();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CfgW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i   = 1'b0;
  endtask

  task automatic set_scoring(logic [7:0] m, logic [7:0] mm, logic [7:0] g, logic loc,
                             logic [6:0] qlen);
    go_idle();
    write_reg(CfgMatch, m);
    write_reg(CfgMismatch, mm);
    write_reg(CfgGap, g);
    write_reg(CfgLocal, {7'd0, loc});
    write_reg(CfgQlen, {1'b0, qlen});
  endtask

  task automatic load_query(bit all_rows);
    for (int i = 0; i < 64; i++) begin
      if (all_rows || $urandom_range(0, 3) == 0) begin
        send_item(ReqQuery, i[5:0], CodeW'($urandom_range(0, 4)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // One subject of random bases; drop in a query reload now and then.
  task automatic send_subject(int unsigned len);
    for (int unsigned k = 1; k <= len; k++) begin
      if ($urandom_range(0, 39) == 0) begin
        send_item(ReqQuery, QidxW'($urandom_range(0, 63)), CodeW'($urandom_range(0, 4)),
                  1'b0);
      end
      send_item(ReqSubject, QidxW'($urandom_range(0, 63)), CodeW'($urandom_range(0, 4)),
                k == len);
    end
  endtask

  task automatic random_phase(int unsigned items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < items) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 12);
      send_busy = ($urandom_range(0, 3) != 0);
      recv_busy = ($urandom_range(0, 3) != 0);
      send_subject(len);
      sent += len;
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    req_type_i    = ReqQuery;
    query_index_i = '0;
    base_code_i   = '0;
    last_base_i   = 1'b0;
    send_busy     = 1'b0;
    recv_busy     = 1'b0;
    quiet_cycles  = 0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: the highest and lowest codes at the two ends of the query, then short
    // subjects of every code under the reset settings.
    load_query(1'b1);
    send_item(ReqQuery, 6'd0, 3'd4, 1'b0);
    send_item(ReqQuery, 6'd63, 3'd0, 1'b1);
    for (int c = 0; c < 5; c++) begin
      send_item(ReqSubject, 6'd63, c[2:0], c == 4);
    end
    send_item(ReqSubject, 6'd0, 3'd4, 1'b1);
    // Local mode where nothing scores positive reports zeros.
    set_scoring(8'sd0, -8'sd1, -8'sd1, 1'b1, 7'd8);
    send_item(ReqSubject, 6'd5, 3'd1, 1'b0);
    send_item(ReqSubject, 6'd5, 3'd2, 1'b1);
    // Equal best cells in several rows and columns.
    set_scoring(8'sd2, 8'sd2, -8'sd1, 1'b1, 7'd4);
    send_item(ReqSubject, 6'd0, 3'd3, 1'b0);
    send_item(ReqSubject, 6'd0, 3'd3, 1'b1);
    // Out-of-range query lengths.
    set_scoring(8'sd3, -8'sd2, -8'sd3, 1'b0, 7'd0);
    send_item(ReqSubject, 6'd1, 3'd2, 1'b1);
    set_scoring(8'sd3, -8'sd2, -8'sd3, 1'b1, 7'd127);
    send_item(ReqSubject, 6'd1, 3'd2, 1'b0);
    send_item(ReqSubject, 6'd1, 3'd2, 1'b1);

    // Random phases across settings, extremes first.
    set_scoring(8'sd127, -8'sd128, -8'sd128, 1'b0, 7'd64);
    random_phase(200);
    set_scoring(-8'sd128, 8'sd127, 8'sd127, 1'b1, 7'd1);
    load_query(1'b1);
    random_phase(200);
    set_scoring(8'sd127, -8'sd128, -8'sd1, 1'b1, 7'd64);
    random_phase(250);
    // Hold off until every result is back before each subject.
    set_scoring(8'sd0, 8'sd0, 8'sd0, 1'b0, 7'd33);
    load_query(1'b0);
    for (int s = 0; s < 8; s++) begin
      go_idle();
      send_subject($urandom_range(1, 10));
    end
    for (int p = 0; p < 6; p++) begin
      set_scoring(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  7'($urandom_range(1, 64)));
      load_query(1'($urandom_range(0, 1)));
      random_phase(200);
    end

    go_idle();
    if (errors == 0 && pending == 0) begin
      $display("[sequence_alignment_score] OK");
    end else begin
      $display("[sequence_alignment_score] ERROR");
    end
    $finish;
  end

endmodule
